@@ sv/lzw_variable_width_decoder_unit_assert.svh @@
// ----------------------------------------------------------------------------
// LZW decoder assertion macros
// Concurrent check wrappers; they expand to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef LZW_VARIABLE_WIDTH_DECODER_UNIT_ASSERT_SVH
`define LZW_VARIABLE_WIDTH_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LZWVD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lzwvd: same-cycle check failed");
// next-cycle implication
`define LZWVD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lzwvd: next-cycle check failed");
`else
`define LZWVD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LZWVD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ sv/lzwvd_pkg.sv @@
// ----------------------------------------------------------------------------
// LZW decoder package
// Sizes, code points, status codes and unit interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwvd_pkg;

   localparam int MAX_CODE_BITS = 12;
   localparam int TABLE_ENTRIES = 3840;
   localparam int STACK_DEPTH   = 4096;

   localparam int CODE_W  = MAX_CODE_BITS;
   localparam int NFC_W   = MAX_CODE_BITS + 1;
   localparam int WIDTH_W = $clog2(MAX_CODE_BITS + 1);
   localparam int TAB_AW  = $clog2(TABLE_ENTRIES);
   localparam int STK_AW  = $clog2(STACK_DEPTH);
   localparam int ACC_W   = 24;
   localparam int HELD_W  = 5;

   localparam logic [CODE_W-1:0]  CODE_CLEAR = CODE_W'(256);
   localparam logic [CODE_W-1:0]  CODE_END   = CODE_W'(257);
   localparam logic [NFC_W-1:0]   NFC_FIRST  = NFC_W'(257);
   localparam logic [NFC_W-1:0]   CODE_LIMIT = NFC_W'(1 << MAX_CODE_BITS);
   localparam logic [WIDTH_W-1:0] MIN_WIDTH  = WIDTH_W'(9);
   localparam logic [WIDTH_W-1:0] MAX_WIDTH  = WIDTH_W'(MAX_CODE_BITS);
   localparam logic [HELD_W-1:0]  HELD_ROOM  = HELD_W'(ACC_W - 8);
   localparam logic [STK_AW-1:0]  STK_LAST   = STK_AW'(STACK_DEPTH - 1);
   localparam logic [STK_AW-1:0]  WALK_STOP  = STK_AW'(STACK_DEPTH - 2);

   // request function
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_PULL = 1'b1;

   // response status
   localparam logic [2:0] STAT_SYMBOL  = 3'd0;
   localparam logic [2:0] STAT_NEED    = 3'd1;
   localparam logic [2:0] STAT_END     = 3'd2;
   localparam logic [2:0] STAT_TAKEN   = 3'd3;
   localparam logic [2:0] STAT_REFUSED = 3'd4;

   typedef struct packed {
      logic push;
      logic take;
   } bits_ctl_type;

   typedef struct packed {
      logic room;
      logic enough;
   } bits_sts_type;

endpackage

`default_nettype wire

@@ sv/lzwvd_req_if.sv @@
// ----------------------------------------------------------------------------
// LZW decoder request channel
// Valid/ready channel carrying one push or pull request per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lzwvd_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] in_byte;

   modport source (output valid, output func, output in_byte, input ready);
   modport sink   (input valid, input func, input in_byte, output ready);
endinterface

`default_nettype wire

@@ sv/lzwvd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// LZW decoder response channel
// Valid/ready channel carrying one symbol/status beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lzwvd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic [2:0] status;

   modport source (output valid, output symbol, output status, input ready);
   modport sink   (input valid, input symbol, input status, output ready);
endinterface

`default_nettype wire

@@ sv/lzwvd_ram.sv @@
// ----------------------------------------------------------------------------
// LZW decoder RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwvd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/lzwvd_bits.sv @@
// ----------------------------------------------------------------------------
// LZW decoder bit unpacker
// 24-bit LSB-first accumulator: appends bytes, peels off variable-width codes.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwvd_bits import lzwvd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  bits_ctl_type       ctl,
   input  logic [7:0]         in_byte,
   input  logic [WIDTH_W-1:0] code_width,
   output bits_sts_type       sts,
   output logic [CODE_W-1:0]  code
);

   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [HELD_W-1:0] held_ff, held_in;
   logic [CODE_W-1:0] mask;

   assign mask       = CODE_W'((NFC_W'(1) << code_width) - NFC_W'(1));
   assign code       = acc_ff[CODE_W-1:0] & mask;
   assign sts.room   = held_ff <= HELD_ROOM;
   assign sts.enough = held_ff >= HELD_W'(code_width);

   always_comb begin
      acc_in  = acc_ff;
      held_in = held_ff;
      if (ctl.push) begin
         acc_in  = acc_ff | (ACC_W'(in_byte) << held_ff);
         held_in = held_ff + HELD_W'(8);
      end else if (ctl.take) begin
         acc_in  = acc_ff >> code_width;
         held_in = held_ff - HELD_W'(code_width);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         held_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/lzw_variable_width_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// LZW variable-width decoder (9 to 12 bit codes, LSB first)
// Push beat: response registered from S_IDLE; one push per cycle while the sink keeps up.
// Pull beat, symbol on stack: stack RAM read in S_IDLE, symbol sent from S_POP.
// Pull beat that decodes: S_FETCH takes any clear codes, then S_WSTART, S_WALK (not for a
//   literal) and S_FINISH; the chain walk does one dictionary RAM read per symbol but the root.
// Need-input and end-code answers come from S_FETCH; a full response register
//   parks any answer in S_EMIT until the sink takes the previous beat.
// Sync reset clears control state; dictionary and stack RAMs are not swept.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lzw_variable_width_decoder_unit_assert.svh"

module lzw_variable_width_decoder_unit import lzwvd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   lzwvd_req_if.sink   req_bus,
   lzwvd_rsp_if.source rsp_bus
);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;  // waiting for a request beat
   localparam logic [2:0] S_FETCH  = 3'd1;  // take codes from the bit unpacker
   localparam logic [2:0] S_WSTART = 3'd2;  // first dictionary read of the chain
   localparam logic [2:0] S_WALK   = 3'd3;  // one chain link per cycle
   localparam logic [2:0] S_FINISH = 3'd4;  // root symbol, table update, response
   localparam logic [2:0] S_POP    = 3'd5;  // stack read data is back
   localparam logic [2:0] S_EMIT   = 3'd6;  // response waits for the output slot

   logic [2:0]         state_ff, state_in;
   logic [WIDTH_W-1:0] width_ff, width_in;
   logic [NFC_W-1:0]   nfc_ff, nfc_in;
   logic [CODE_W-1:0]  prev_ff, prev_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic [CODE_W-1:0]  val_ff, val_in;
   logic [STK_AW-1:0]  count_ff, count_in;

   // output register and the parked response behind it
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_symbol_ff, rsp_symbol_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic [7:0] res_symbol_ff, res_symbol_in;
   logic [2:0] res_status_ff, res_status_in;

   logic       res_fire;
   logic [7:0] res_symbol;
   logic [2:0] res_status;

   logic req_fire;
   logic out_free;
   logic can_write;
   logic [TAB_AW-1:0] nfc_idx;
   logic [NFC_W-1:0]  nfc_inc;

   // bit unpacker
   bits_ctl_type      bits_ctl;
   bits_sts_type      bits_sts;
   logic [CODE_W-1:0] code;

   // dictionary ports (prefix and suffix share the read address)
   logic              dict_rd_en;
   logic [TAB_AW-1:0] dict_rd_addr;
   logic              prefix_we;
   logic              suffix_we;
   logic [7:0]        suffix_rd;
   logic [CODE_W-1:0] prefix_rd;

   // output stack ports
   logic              stk_we;
   logic [STK_AW-1:0] stk_wr_addr;
   logic [7:0]        stk_wr_data;
   logic              stk_rd_en;
   logic [STK_AW-1:0] stk_rd_addr;
   logic [7:0]        stk_rd_data;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   // Once the next free code saturates, the dictionary is frozen.
   assign can_write = nfc_ff < CODE_LIMIT;
   assign nfc_idx   = TAB_AW'(nfc_ff - NFC_W'(CODE_CLEAR));
   assign nfc_inc   = can_write ? nfc_ff + NFC_W'(1) : nfc_ff;

   assign req_bus.ready  = state_ff == S_IDLE;
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.symbol = rsp_symbol_ff;
   assign rsp_bus.status = rsp_status_ff;

   lzwvd_bits u_bits (
      .clock      (clock),
      .reset      (reset),
      .ctl        (bits_ctl),
      .in_byte    (req_bus.in_byte),
      .code_width (width_ff),
      .sts        (bits_sts),
      .code       (code)
   );

   lzwvd_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_suffix (
      .clock   (clock),
      .wr_en   (suffix_we),
      .wr_addr (nfc_idx),
      .wr_data (val_ff[7:0]),
      .rd_en   (dict_rd_en),
      .rd_addr (dict_rd_addr),
      .rd_data (suffix_rd)
   );

   lzwvd_ram #(.WIDTH(CODE_W), .DEPTH(TABLE_ENTRIES)) u_prefix (
      .clock   (clock),
      .wr_en   (prefix_we),
      .wr_addr (nfc_idx),
      .wr_data (prev_ff),
      .rd_en   (dict_rd_en),
      .rd_addr (dict_rd_addr),
      .rd_data (prefix_rd)
   );

   lzwvd_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      width_in      = width_ff;
      nfc_in        = nfc_ff;
      prev_in       = prev_ff;
      code_in       = code_ff;
      val_in        = val_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_status_in = rsp_status_ff;
      res_symbol_in = res_symbol_ff;
      res_status_in = res_status_ff;

      res_fire   = 1'b0;
      res_symbol = '0;
      res_status = STAT_SYMBOL;

      bits_ctl     = '0;
      dict_rd_en   = 1'b0;
      dict_rd_addr = TAB_AW'(val_ff - CODE_CLEAR);
      prefix_we    = 1'b0;
      suffix_we    = 1'b0;
      stk_we       = 1'b0;
      stk_wr_addr  = count_ff;
      stk_wr_data  = suffix_rd;
      stk_rd_en    = 1'b0;
      stk_rd_addr  = count_ff - STK_AW'(1);

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_bus.func == FUNC_PUSH) begin
                  // byte lands above the held bits if there is room
                  bits_ctl.push = bits_sts.room;
                  res_fire      = 1'b1;
                  res_status    = bits_sts.room ? STAT_TAKEN : STAT_REFUSED;
               end else if (count_ff != '0) begin
                  stk_rd_en = 1'b1;
                  count_in  = count_ff - STK_AW'(1);
                  state_in  = S_POP;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end

         S_POP: begin
            res_fire   = 1'b1;
            res_symbol = stk_rd_data;
         end

         S_FETCH: begin
            if (!bits_sts.enough) begin
               // clears already taken stay in effect
               res_fire   = 1'b1;
               res_status = STAT_NEED;
            end else begin
               bits_ctl.take = 1'b1;
               if (code == CODE_CLEAR) begin
                  width_in = MIN_WIDTH;
                  nfc_in   = NFC_FIRST;
               end else if (code == CODE_END) begin
                  res_fire   = 1'b1;
                  res_status = STAT_END;
               end else begin
                  // new entry's prefix goes in now so a KwKwK code can walk it
                  prefix_we = can_write;
                  code_in   = code;
                  val_in    = code;
                  state_in  = S_WSTART;
               end
            end
         end

         S_WSTART: begin
            if (val_ff > CODE_CLEAR) begin
               dict_rd_en = 1'b1;
               state_in   = S_WALK;
            end else begin
               state_in = S_FINISH;
            end
         end

         S_WALK: begin
            // push this link's suffix, follow its prefix
            stk_we   = 1'b1;
            count_in = count_ff + STK_AW'(1);
            if (prefix_rd > CODE_CLEAR && count_ff < WALK_STOP) begin
               dict_rd_en   = 1'b1;
               dict_rd_addr = TAB_AW'(prefix_rd - CODE_CLEAR);
            end else begin
               val_in   = prefix_rd;
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            // The root symbol would be the top of the stack and is popped at
            // once, so it goes straight to the response.
            res_fire   = 1'b1;
            res_symbol = val_ff[7:0];
            suffix_we  = can_write;
            // KwKwK: the last symbol of the string becomes its first one
            if (NFC_W'(code_ff) == nfc_ff) begin
               stk_we      = 1'b1;
               stk_wr_addr = '0;
               stk_wr_data = val_ff[7:0];
            end
            prev_in = code_ff;
            nfc_in  = nfc_inc;
            if (nfc_inc == (NFC_W'(1) << width_ff) && width_ff < MAX_WIDTH) begin
               width_in = width_ff + WIDTH_W'(1);
            end
         end

         S_EMIT: begin
            res_fire   = 1'b1;
            res_symbol = res_symbol_ff;
            res_status = res_status_ff;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A finished response goes to the output register if it is free,
      // otherwise it is parked until the sink takes the previous beat.
      if (res_fire) begin
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            rsp_symbol_in = res_symbol;
            rsp_status_in = res_status;
            state_in      = S_IDLE;
         end else begin
            res_symbol_in = res_symbol;
            res_status_in = res_status;
            state_in      = S_EMIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= MIN_WIDTH;
         nfc_ff       <= NFC_FIRST;
         prev_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         nfc_ff       <= nfc_in;
         prev_ff      <= prev_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff       <= code_in;
      val_ff        <= val_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_status_ff <= rsp_status_in;
      res_symbol_ff <= res_symbol_in;
      res_status_ff <= res_status_in;
   end

   // chain walk never runs the stack past its last slot
   `LZWVD_ASSERT_IMP(a_walk_room, clock, reset, state_ff == S_WALK, count_ff != STK_LAST)
   // codes are only fetched with an empty stack
   `LZWVD_ASSERT_IMP(a_fetch_empty, clock, reset, state_ff == S_FETCH, count_ff == '0)
   `LZWVD_ASSERT_IMP(a_width_range, clock, reset, 1'b1, width_ff >= MIN_WIDTH && width_ff <= MAX_WIDTH)
   `LZWVD_ASSERT_IMP(a_nfc_range, clock, reset, 1'b1, nfc_ff >= NFC_FIRST && nfc_ff <= CODE_LIMIT)
   // a push beat is answered without touching the decode path
   `LZWVD_ASSERT_NXT(a_push_done, clock, reset, req_fire && req_bus.func == FUNC_PUSH, state_ff == S_IDLE || state_ff == S_EMIT)

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// LZW variable-width decoder testbench
// Feeds well-formed LSB-first code streams with random content, plus pulls,
// refused pushes and idle bursts on both channels, and checks every response
// beat in order against a scoreboard that decodes the same request beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import lzwvd_pkg::*;

   // one response beat as the scoreboard expects it
   typedef struct packed {
      logic [7:0] symbol;
      logic [2:0] status;
   } rsp_beat_type;

   // Scoreboard: keeps its own copy of the dictionary, the output stack and
   // the bit accumulator, and turns each accepted request into the response
   // beat it must cause.
   class decode_scoreboard;
      logic [7:0]         dict_suffix [TABLE_ENTRIES];
      logic [CODE_W-1:0]  dict_prefix [TABLE_ENTRIES];
      logic [7:0]         string_stack [STACK_DEPTH];
      logic [STK_AW:0]    stack_fill;
      logic [ACC_W-1:0]   acc_bits;
      logic [HELD_W-1:0]  acc_count;
      logic [WIDTH_W-1:0] width;
      logic [NFC_W-1:0]   next_code;
      logic [CODE_W-1:0]  last_code;

      rsp_beat_type due_beats [$];
      logic [2:0]   last_status;
      int           tally [5];
      int           errors;
      int           matched;
      int           widest;
      bit           saturated;

      function new();
         foreach (dict_suffix[i]) dict_suffix[i] = '0;
         foreach (dict_prefix[i]) dict_prefix[i] = '0;
         foreach (string_stack[i]) string_stack[i] = '0;
         stack_fill = '0;
         acc_bits   = '0;
         acc_count  = '0;
         width      = MIN_WIDTH;
         next_code  = NFC_FIRST;
         last_code  = '0;
         foreach (tally[i]) tally[i] = 0;
         errors    = 0;
         matched   = 0;
         widest    = MIN_WIDTH;
         saturated = 1'b0;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10)
            $display("tb: mismatch %0d at %0t: %s", errors, $realtime, msg);
      endfunction

      function void stack_push(int v);
         if (stack_fill < STACK_DEPTH) begin
            string_stack[stack_fill] = v[7:0];
            stack_fill++;
         end
      endfunction

      // decode one code onto the stack and grow the dictionary
      function void expand_code(int code);
         int  nfc;
         int  val;
         int  idx;
         int  s;
         int  p;
         bit  can_write;
         nfc = next_code;
         can_write = nfc < CODE_LIMIT && (nfc - 256) < TABLE_ENTRIES;
         if (can_write)
            dict_prefix[nfc-256] = last_code;
         stack_fill = '0;
         val = code;
         while (val > 256 && stack_fill < STACK_DEPTH - 1) begin
            idx = val - 256;
            s = 0;
            p = 0;
            if (idx < TABLE_ENTRIES) begin
               s = dict_suffix[idx];
               p = dict_prefix[idx];
            end
            stack_push(s);
            val = p;
         end
         stack_push(val);
         // repeated pattern: the string ends with its own first symbol
         if (code == nfc)
            string_stack[0] = val[7:0];
         if (can_write)
            dict_suffix[nfc-256] = val[7:0];
         last_code = code;
         if (nfc < CODE_LIMIT)
            next_code++;
         if (next_code == (1 << width) && width < MAX_WIDTH)
            width++;
         if (width > widest)
            widest = width;
         if (next_code == CODE_LIMIT)
            saturated = 1'b1;
      endfunction

      function void note_request(logic func, logic [7:0] data);
         rsp_beat_type r;
         int           code;
         int           c;
         r.symbol = '0;
         if (func == FUNC_PUSH) begin
            if (acc_count <= HELD_ROOM) begin
               acc_bits  = acc_bits | (ACC_W'(data) << acc_count);
               acc_count = acc_count + 5'd8;
               r.status  = STAT_TAKEN;
            end else begin
               r.status = STAT_REFUSED;
            end
         end else begin
            r.status = STAT_SYMBOL;
            if (stack_fill == 0) begin
               code = -1;
               // clears are applied on the way and stay applied
               while (code < 0 && acc_count >= width) begin
                  c = int'(acc_bits & ACC_W'((1 << width) - 1));
                  acc_bits  = acc_bits >> width;
                  acc_count = acc_count - HELD_W'(width);
                  if (c == CODE_CLEAR) begin
                     width     = MIN_WIDTH;
                     next_code = NFC_FIRST;
                  end else begin
                     code = c;
                  end
               end
               if (code < 0)
                  r.status = STAT_NEED;
               else if (code == CODE_END)
                  r.status = STAT_END;
               else
                  expand_code(code);
            end
            if (r.status == STAT_SYMBOL) begin
               stack_fill--;
               r.symbol = string_stack[stack_fill];
            end
         end
         last_status = r.status;
         tally[r.status]++;
         due_beats.push_back(r);
      endfunction

      function void check_response(logic [7:0] symbol, logic [2:0] status);
         rsp_beat_type e;
         if (due_beats.size() == 0) begin
            flag($sformatf("unexpected beat symbol %02h status %0d", symbol, status));
         end else begin
            e = due_beats.pop_front();
            if (e.symbol !== symbol || e.status !== status)
               flag($sformatf("expected symbol %02h status %0d, got symbol %02h status %0d",
                              e.symbol, e.status, symbol, status));
            else
               matched++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   lzwvd_req_if req_bus ();
   lzwvd_rsp_if rsp_bus ();

   lzw_variable_width_decoder_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #4 clock = ~clock;

   decode_scoreboard sb;
   int idle_pct = 0;     // percent chance of an idle burst, per request beat and per ready sample
   int beats_sent = 0;

   // Stream generator: tracks width and next free code exactly as the
   // decoder will see them, so every code it emits is defined at decode time.
   int gen_width;
   int gen_next;
   bit code_bits [$];    // packed stream bits not yet pushed, LSB first

   // Response sink: ready drops in bursts of random length while idle_pct is set.
   initial begin : rsp_sink
      int stall;
      stall = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            stall = $urandom_range(1, 3) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Response monitor: sampled at the rising edge.
   always @(posedge clock)
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         sb.check_response(rsp_bus.symbol, rsp_bus.status);

   // Append one code at the current width and advance the generator state.
   function automatic void pack_code(int code);
      for (int i = 0; i < gen_width; i++)
         code_bits.push_back(code[i]);
      if (code == CODE_CLEAR) begin
         gen_width = MIN_WIDTH;
         gen_next  = NFC_FIRST;
      end else if (code != CODE_END) begin
         if (gen_next < CODE_LIMIT)
            gen_next++;
         if (gen_next == (1 << gen_width) && gen_width < MAX_CODE_BITS)
            gen_width++;
      end
   endfunction

   // Weights are per mille; whatever is left goes to literals.
   function automatic int choose_code(int clear_pm, int end_pm, int repeat_pm,
                                      int reuse_pm);
      int r;
      r = $urandom_range(0, 999);
      if (r < clear_pm)
         return CODE_CLEAR;
      r -= clear_pm;
      if (r < end_pm)
         return CODE_END;
      r -= end_pm;
      // repeated pattern needs a previous code in this dictionary
      if (r < repeat_pm && gen_next > NFC_FIRST && gen_next < CODE_LIMIT)
         return gen_next;
      r -= repeat_pm;
      if (r < reuse_pm && gen_next > NFC_FIRST + 1)
         return $urandom_range(NFC_FIRST + 1, gen_next - 1);
      return $urandom_range(0, 255);
   endfunction

   function automatic logic [7:0] take_stream_byte();
      logic [7:0] b;
      for (int i = 0; i < 8; i++)
         b[i] = code_bits.pop_front();
      return b;
   endfunction

   // One request beat; returns at the falling edge after acceptance with
   // valid still high, so the caller either sends again or drops it.
   task automatic send_beat(logic func, logic [7:0] data);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.func    <= func;
      req_bus.in_byte <= data;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_request(func, data);
      beats_sent++;
      @(negedge clock);
   endtask

   // Push the next stream byte when it fits, else pull; a little noise:
   // refused pushes of junk and extra pulls.
   task automatic step_stream(int pull_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) begin
         if (sb.acc_count > HELD_ROOM)
            send_beat(FUNC_PUSH, 8'($urandom));
         else
            send_beat(FUNC_PULL, 8'($urandom));
      end else if (code_bits.size() >= 8 && sb.acc_count <= HELD_ROOM && r >= pull_pct) begin
         send_beat(FUNC_PUSH, take_stream_byte());
      end else begin
         send_beat(FUNC_PULL, 8'($urandom));
      end
   endtask

   task automatic play_codes(int n, int pull_pct, int clear_pm, int end_pm,
                             int repeat_pm, int reuse_pm);
      repeat (n) begin
         pack_code(choose_code(clear_pm, end_pm, repeat_pm, reuse_pm));
         while (code_bits.size() >= 8)
            step_stream(pull_pct);
      end
   endtask

   // Pull until the decoder runs dry: stack empty and too few bits held.
   task automatic pull_until_starved();
      do send_beat(FUNC_PULL, 8'($urandom)); while (sb.last_status != STAT_NEED);
   endtask

   // Sender holds off until every expected beat has come back.
   task automatic wait_all_symbols();
      req_bus.valid <= 1'b0;
      while (sb.due_beats.size() != 0)
         @(negedge clock);
   endtask

   initial begin : stimulus
      int opening [9];
      int n;
      opening = '{CODE_CLEAR, 255, 0, 258, 260, CODE_END,
                  CODE_CLEAR, CODE_CLEAR, 65};
      req_bus.valid   = 1'b0;
      req_bus.func    = FUNC_PUSH;
      req_bus.in_byte = 8'h00;
      sb = new();
      gen_width = MIN_WIDTH;
      gen_next  = NFC_FIRST;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed opening ---
      // nothing loaded yet: need input
      send_beat(FUNC_PULL, 8'hff);
      // clear, extreme literals, a defined code, the repeated pattern,
      // end code, back-to-back clears, then a literal
      foreach (opening[i])
         pack_code(opening[i]);
      repeat (3) send_beat(FUNC_PUSH, take_stream_byte());
      // 24 bits held: this byte bounces
      send_beat(FUNC_PUSH, 8'hff);
      while (code_bits.size() >= 8)
         step_stream(0);
      pull_until_starved();
      wait_all_symbols();

      // --- random streams ---
      idle_pct = 15;
      // a run of repeated patterns builds one long chain after another
      play_codes(24, 30, 0, 0, 1000, 0);
      while (beats_sent < 600) begin
         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 10;
            default: idle_pct = 30;
         endcase
         play_codes($urandom_range(10, 40), $urandom_range(0, 60), 4, 25, 80, 450);
         if ($urandom_range(0, 3) == 0)
            wait_all_symbols();
      end
      pull_until_starved();
      wait_all_symbols();

      // --- grow the dictionary past 9-bit codes ---
      idle_pct = 5;
      pack_code(CODE_CLEAR);
      while (gen_next < 530)
         play_codes(1, 20, 0, 2, 10, 60);
      pull_until_starved();
      wait_all_symbols();

      // --- closing stretch, no idling ---
      idle_pct = 0;
      play_codes(40, 20, 4, 25, 80, 450);
      pull_until_starved();
      req_bus.valid <= 1'b0;

      // drain, then let the pipe settle
      n = 0;
      while (sb.due_beats.size() != 0 && n < 100000) begin
         @(negedge clock);
         n++;
      end
      repeat (50) @(negedge clock);
      while (sb.due_beats.size() != 0) begin
         sb.flag($sformatf("expected symbol %02h status %0d never arrived",
                           sb.due_beats[0].symbol, sb.due_beats[0].status));
         void'(sb.due_beats.pop_front());
      end

      $display("tb: %0d request beats, %0d responses matched (%0d symbols, %0d need, %0d end, %0d taken, %0d refused)",
               beats_sent, sb.matched, sb.tally[STAT_SYMBOL], sb.tally[STAT_NEED],
               sb.tally[STAT_END], sb.tally[STAT_TAKEN], sb.tally[STAT_REFUSED]);
      $display("tb: widest code %0d bits, dictionary filled %0s, %0d mismatches",
               sb.widest, sb.saturated ? "yes" : "no", sb.errors);
      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // watchdog
   initial begin
      #10ms;
      $display("tb: failure");
      $finish;
   end

endmodule
